[sv/mmf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package mmf_pkg;

	localparam int CHANNELS   = 4;
	localparam int WINDOW     = 5;
	localparam int SLOT_W     = $clog2(WINDOW);
	localparam int MASK_W     = CHANNELS;

	localparam int CODE_W     = 16;
	localparam int MAG_W      = CODE_W + 1;
	localparam int UV_W       = 24;
	localparam int FS_W       = 13;
	localparam int FSK_W      = 23;   // full_scale_mv * 1000, max 8191000
	localparam int PROD_W     = 38;   // |code| * fs * 1000 < 2^38
	localparam int DIV_SHIFT  = 15;   // divisor is 2^15 - 1
	localparam int QUO_W      = PROD_W - DIV_SHIFT;
	localparam int REM1_W     = QUO_W + 1;
	localparam int REM2_W     = DIV_SHIFT + 1;

	localparam logic [REM2_W-1:0] CODE_MAX = REM2_W'((1 << DIV_SHIFT) - 1);

	localparam logic [FS_W-1:0]  FS_RESET  = FS_W'(4096);
	localparam logic [FSK_W-1:0] FSK_RESET = FSK_W'(4096 * 1000);

	localparam int IN_DATA_W  = CHANNELS * CODE_W;
	localparam int OUT_DATA_W = CHANNELS * (CODE_W + UV_W);

	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam int REG_IDX_W  = CFG_ADDR_W - 2;
	localparam logic [REG_IDX_W-1:0] REG_FULL_SCALE = '0;

	typedef logic signed [CODE_W-1:0] code_t;
	typedef logic signed [UV_W-1:0]   uv_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SORT,
		ST_PICK,
		ST_MUL,
		ST_DIV1,
		ST_DIV2,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic              wr;     // round accepted, update windows
		logic [SLOT_W-1:0] slot;   // shared write index
		logic              fill;   // window not yet wrapped: fill all taps
		logic              en_s1;
		logic              en_s2;
		logic              en_s3;
		logic              en_s4;
		logic              en_s5;
	} ctrl_t;

endpackage

`default_nettype wire

[sv/mmf_scale.sv]
`timescale 1ns / 1ps
`default_nettype none

// |median| * fs * 1000 / 32767, truncated toward zero, sign restored.
module mmf_scale (
	input  logic                          clk,
	input  mmf_pkg::ctrl_t                ctrl,
	input  logic [mmf_pkg::MAG_W-1:0]     mag,
	input  logic                          neg,
	input  logic [mmf_pkg::FSK_W-1:0]     fs_k,
	output mmf_pkg::uv_t                  microvolts
);

	logic [mmf_pkg::MAG_W+mmf_pkg::FSK_W-1:0] prod_full;
	logic [mmf_pkg::PROD_W-1:0]  prod_s3;
	logic                        neg_s3, neg_s4, neg_s5;
	logic [mmf_pkg::QUO_W-1:0]   q_s4, q_s5, q_fix;
	logic [mmf_pkg::REM1_W-1:0]  r_s4;
	logic [mmf_pkg::REM2_W-1:0]  r_s5;
	logic [mmf_pkg::REM1_W-mmf_pkg::DIV_SHIFT-1:0] r_hi;
	logic [mmf_pkg::UV_W-1:0]    mag_uv;

	assign prod_full = mag * fs_k;
	assign r_hi      = r_s4[mmf_pkg::REM1_W-1:mmf_pkg::DIV_SHIFT];

	// x = hi*2^15 + lo = hi*(2^15-1) + (hi + lo): fold twice, then one correction
	always_ff @(posedge clk) begin
		if (ctrl.en_s3) begin
			prod_s3 <= prod_full[mmf_pkg::PROD_W-1:0];
			neg_s3  <= neg;
		end
		if (ctrl.en_s4) begin
			q_s4   <= prod_s3[mmf_pkg::PROD_W-1:mmf_pkg::DIV_SHIFT];
			r_s4   <= mmf_pkg::REM1_W'(prod_s3[mmf_pkg::PROD_W-1:mmf_pkg::DIV_SHIFT])
				+ mmf_pkg::REM1_W'(prod_s3[mmf_pkg::DIV_SHIFT-1:0]);
			neg_s4 <= neg_s3;
		end
		if (ctrl.en_s5) begin
			q_s5   <= q_s4 + mmf_pkg::QUO_W'(r_hi);
			r_s5   <= mmf_pkg::REM2_W'(r_hi) + mmf_pkg::REM2_W'(r_s4[mmf_pkg::DIV_SHIFT-1:0]);
			neg_s5 <= neg_s4;
		end
	end

	assign q_fix      = q_s5 + mmf_pkg::QUO_W'(r_s5 >= mmf_pkg::CODE_MAX);
	assign mag_uv     = mmf_pkg::UV_W'(q_fix);
	assign microvolts = neg_s5 ? -mag_uv : mag_uv;

endmodule

`default_nettype wire

[sv/mmf_lane.sv]
`timescale 1ns / 1ps
`default_nettype none

// One channel: five-tap window, median network over two stages, scaler.
module mmf_lane (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mmf_pkg::ctrl_t                ctrl,
	input  mmf_pkg::code_t                code,
	input  logic                          ok,
	input  logic [mmf_pkg::FSK_W-1:0]     fs_k,
	output mmf_pkg::code_t                median,
	output mmf_pkg::uv_t                  microvolts
);

	mmf_pkg::code_t win_q [mmf_pkg::WINDOW];
	logic           ok_q;

	mmf_pkg::code_t a1, b1, c1, d1;
	mmf_pkg::code_t plo_s1, phi_s1, u_s1, e_s1;
	mmf_pkg::code_t lo2, hi2, med;
	mmf_pkg::code_t med_s2;
	logic signed [mmf_pkg::MAG_W-1:0] med_x;
	logic [mmf_pkg::MAG_W-1:0]        mag_s2;
	logic                             neg_s2;
	mmf_pkg::uv_t                     uv_raw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < mmf_pkg::WINDOW; i++) begin
				win_q[i] <= '0;
			end
			ok_q <= 1'b0;
		end else if (ctrl.wr) begin
			ok_q <= ok;
			if (ok) begin
				for (int i = 0; i < mmf_pkg::WINDOW; i++) begin
					if (ctrl.fill || ctrl.slot == mmf_pkg::SLOT_W'(i)) begin
						win_q[i] <= code;
					end
				end
			end
		end
	end

	// stage 1: sort two pairs, drop the least of the four (cannot be the median)
	always_comb begin
		a1 = (win_q[0] <= win_q[1]) ? win_q[0] : win_q[1];
		b1 = (win_q[0] <= win_q[1]) ? win_q[1] : win_q[0];
		c1 = (win_q[2] <= win_q[3]) ? win_q[2] : win_q[3];
		d1 = (win_q[2] <= win_q[3]) ? win_q[3] : win_q[2];
	end

	always_ff @(posedge clk) begin
		if (ctrl.en_s1) begin
			if (a1 <= c1) begin
				plo_s1 <= c1;
				phi_s1 <= d1;
				u_s1   <= b1;
			end else begin
				plo_s1 <= a1;
				phi_s1 <= b1;
				u_s1   <= d1;
			end
			e_s1 <= win_q[4];
		end
	end

	// stage 2: median = second smallest of the remaining four
	always_comb begin
		lo2 = (u_s1 <= e_s1) ? u_s1 : e_s1;
		hi2 = (u_s1 <= e_s1) ? e_s1 : u_s1;
		if (lo2 < plo_s1) begin
			med = (hi2 < plo_s1) ? hi2 : plo_s1;
		end else begin
			med = (phi_s1 < lo2) ? phi_s1 : lo2;
		end
	end

	assign med_x = mmf_pkg::MAG_W'(med_s2);

	always_ff @(posedge clk) begin
		if (ctrl.en_s2) begin
			med_s2 <= med;
		end
	end

	assign neg_s2 = med_x[mmf_pkg::MAG_W-1];
	assign mag_s2 = neg_s2 ? -med_x : med_x;

	mmf_scale u_scale (
		.clk        (clk),
		.ctrl       (ctrl),
		.mag        (mag_s2),
		.neg        (neg_s2),
		.fs_k       (fs_k),
		.microvolts (uv_raw)
	);

	assign median     = ok_q ? med_s2 : '0;
	assign microvolts = ok_q ? uv_raw : '0;

endmodule

`default_nettype wire

[sv/mmf_merge.sv]
`timescale 1ns / 1ps
`default_nettype none

// Gathers the lane results into one output transfer.
module mmf_merge (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               load,
	input  mmf_pkg::code_t                     median [mmf_pkg::CHANNELS],
	input  mmf_pkg::uv_t                       microvolts [mmf_pkg::CHANNELS],
	input  logic [mmf_pkg::MASK_W-1:0]         mask,
	input  logic                               m_tready,
	output logic                               m_tvalid,
	output logic [mmf_pkg::OUT_DATA_W-1:0]     m_tdata,
	output logic [mmf_pkg::MASK_W-1:0]         m_tuser
);

	logic                              valid_q;
	logic [mmf_pkg::OUT_DATA_W-1:0]    data_q;
	logic [mmf_pkg::MASK_W-1:0]        user_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < mmf_pkg::CHANNELS; i++) begin
				data_q[i*mmf_pkg::CODE_W +: mmf_pkg::CODE_W] <= median[i];
				data_q[mmf_pkg::CHANNELS*mmf_pkg::CODE_W + i*mmf_pkg::UV_W +: mmf_pkg::UV_W]
					<= microvolts[i];
			end
			user_q <= mask;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;
	assign m_tuser  = user_q;

endmodule

`default_nettype wire

[sv/multichannel_median_filter_top.sv]
// Path from the input transfer to m_tvalid: window write, two median stages,
//   multiply, two fold stages of the divide by 32767, output register.
// Rounds are handled one at a time by the single-item sequencer; a new
//   round is taken in the cycle its predecessor moves into the output register.
// Reset (arst_n low, asynchronous): windows zero, write slot 0, not wrapped,
//   full_scale_mv 4096, no result pending.
`timescale 1ns / 1ps
`default_nettype none

module multichannel_median_filter_top (
	input  logic                              clk,
	input  logic                              arst_n,
	// input stream
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [mmf_pkg::IN_DATA_W-1:0]     s_tdata,   // code_ch0..code_ch3
	input  logic [mmf_pkg::MASK_W-1:0]        s_tuser,   // ok_mask
	// output stream
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [mmf_pkg::OUT_DATA_W-1:0]    m_tdata,   // median_ch0..3, microvolts_ch0..3
	output logic [mmf_pkg::MASK_W-1:0]        m_tuser,   // valid_mask
	// register port
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [mmf_pkg::CFG_ADDR_W-1:0]    paddr,
	input  logic [mmf_pkg::CFG_DATA_W-1:0]    pwdata,
	output logic [mmf_pkg::CFG_DATA_W-1:0]    prdata,
	output logic                              pready
);

	mmf_pkg::state_t               state_q, state_nxt;
	mmf_pkg::ctrl_t                ctrl;
	logic [mmf_pkg::SLOT_W-1:0]    slot_q;
	logic                          wrapped_q;
	logic [mmf_pkg::MASK_W-1:0]    mask_q;
	logic [mmf_pkg::FS_W-1:0]      fs_q, wfs;
	logic [mmf_pkg::FSK_W-1:0]     fs_k_q, wfs_k;
	logic [mmf_pkg::REG_IDX_W-1:0] reg_idx;
	logic                          cfg_wr;
	logic                          out_free;
	logic                          load_out;
	logic                          accept;

	mmf_pkg::code_t lane_med [mmf_pkg::CHANNELS];
	mmf_pkg::uv_t   lane_uv  [mmf_pkg::CHANNELS];

	//------------------------------------------------------------------
	// Register port: single register, no wait states.
	// fs*1000 is formed once at write time (1024 - 16 - 8) so the lanes
	// need only one multiply.
	//------------------------------------------------------------------
	assign pready  = 1'b1;
	assign reg_idx = paddr[mmf_pkg::CFG_ADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite && pready
		&& (reg_idx == mmf_pkg::REG_FULL_SCALE);
	assign wfs     = pwdata[mmf_pkg::FS_W-1:0];
	assign wfs_k   = {wfs, 10'b0} - mmf_pkg::FSK_W'({wfs, 4'b0})
		- mmf_pkg::FSK_W'({wfs, 3'b0});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fs_q   <= mmf_pkg::FS_RESET;
			fs_k_q <= mmf_pkg::FSK_RESET;
		end else if (cfg_wr) begin
			fs_q   <= wfs;
			fs_k_q <= wfs_k;
		end
	end

	always_comb begin
		case (reg_idx)
			mmf_pkg::REG_FULL_SCALE: prdata = mmf_pkg::CFG_DATA_W'(fs_q);
			default:                 prdata = '0;
		endcase
	end

	//------------------------------------------------------------------
	// Sequencer: one round in flight. The result stage waits in ST_DONE
	// until the output register is free; the next round can be taken
	// in that same cycle since the windows are no longer read by then.
	//------------------------------------------------------------------
	assign out_free = !m_tvalid || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mmf_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			mmf_pkg::ST_IDLE: begin
				if (s_tvalid) state_nxt = mmf_pkg::ST_SORT;
			end
			mmf_pkg::ST_SORT: state_nxt = mmf_pkg::ST_PICK;
			mmf_pkg::ST_PICK: state_nxt = mmf_pkg::ST_MUL;
			mmf_pkg::ST_MUL:  state_nxt = mmf_pkg::ST_DIV1;
			mmf_pkg::ST_DIV1: state_nxt = mmf_pkg::ST_DIV2;
			mmf_pkg::ST_DIV2: state_nxt = mmf_pkg::ST_DONE;
			mmf_pkg::ST_DONE: begin
				if (out_free) begin
					state_nxt = s_tvalid ? mmf_pkg::ST_SORT : mmf_pkg::ST_IDLE;
				end
			end
			default: state_nxt = mmf_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready   = 1'b0;
		load_out   = 1'b0;
		ctrl       = '0;
		ctrl.slot  = slot_q;
		ctrl.fill  = !wrapped_q;
		case (state_q)
			mmf_pkg::ST_IDLE: s_tready = 1'b1;
			mmf_pkg::ST_SORT: ctrl.en_s1 = 1'b1;
			mmf_pkg::ST_PICK: ctrl.en_s2 = 1'b1;
			mmf_pkg::ST_MUL:  ctrl.en_s3 = 1'b1;
			mmf_pkg::ST_DIV1: ctrl.en_s4 = 1'b1;
			mmf_pkg::ST_DIV2: ctrl.en_s5 = 1'b1;
			mmf_pkg::ST_DONE: begin
				s_tready = out_free;
				load_out = out_free;
			end
			default: ;
		endcase
		ctrl.wr = s_tvalid && s_tready;
	end

	assign accept = ctrl.wr;

	// shared write slot advances on every round, mask or not
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q    <= '0;
			wrapped_q <= 1'b0;
			mask_q    <= '0;
		end else if (accept) begin
			mask_q <= s_tuser;
			if (slot_q == mmf_pkg::SLOT_W'(mmf_pkg::WINDOW - 1)) begin
				slot_q    <= '0;
				wrapped_q <= 1'b1;
			end else begin
				slot_q <= slot_q + 1'b1;
			end
		end
	end

	//------------------------------------------------------------------
	// Lanes: one per channel, all driven by the same control word.
	//------------------------------------------------------------------
	for (genvar ch = 0; ch < mmf_pkg::CHANNELS; ch++) begin : g_lane
		mmf_lane u_lane (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.code       (s_tdata[ch*mmf_pkg::CODE_W +: mmf_pkg::CODE_W]),
			.ok         (s_tuser[ch]),
			.fs_k       (fs_k_q),
			.median     (lane_med[ch]),
			.microvolts (lane_uv[ch])
		);
	end

	mmf_merge u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (load_out),
		.median     (lane_med),
		.microvolts (lane_uv),
		.mask       (mask_q),
		.m_tready   (m_tready),
		.m_tvalid   (m_tvalid),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser)
	);

	//------------------------------------------------------------------
	// Checks
	//------------------------------------------------------------------
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		slot_q <= mmf_pkg::SLOT_W'(mmf_pkg::WINDOW - 1))
		else $error("write slot out of range");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == mmf_pkg::ST_SORT)
		else $error("accepted round did not start the median stages");

	a_done_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mmf_pkg::ST_DONE && out_free) |=> m_tvalid)
		else $error("finished round not presented");

	a_wrap_sets: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && slot_q == mmf_pkg::SLOT_W'(mmf_pkg::WINDOW - 1)) |=> wrapped_q)
		else $error("window wrap flag not set at slot wrap");

endmodule

`default_nettype wire
